FILE: rtl/ptig_pkg.sv
// Package: constants and types for the per-tag interval gate
`default_nettype none
package ptig_pkg;
  localparam int unsigned Entries   = 64;
  localparam int unsigned TagBytes  = 5;
  localparam int unsigned TagW      = 40;
  localparam int unsigned IdxW      = $clog2(Entries);
  localparam int unsigned CntW      = $clog2(Entries + 1);
  localparam int unsigned MsPerSec  = 1000;
  // ceil(2^38 / 1000): x / 1000 == (x * DivMagic) >> 38 for any 32-bit x
  localparam logic [28:0] DivMagic  = 29'd274877907;
  localparam logic [TagW-1:0] TagMask =
    (TagBytes >= 8) ? {TagW{1'b1}} : TagW'((64'd1 << (8 * TagBytes)) - 64'd1);

  localparam logic [1:0] OpClock = 2'd0;
  localparam logic [1:0] OpCheck = 2'd1;
  localparam logic [1:0] OpAdd   = 2'd2;
  localparam logic [1:0] OpClear = 2'd3;

  // One table entry as held in memory
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [7:0]      interval;
    logic [31:0]     elapsed;
    logic [31:0]     last_taken;
  } entry_t;
  localparam int unsigned EntryW = $bits(entry_t);
endpackage
`default_nettype wire

FILE: rtl/ptig_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module ptig_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/per_tag_interval_gate.sv
// Top level: per-tag interval gate with sequenced table scans
//
//  channel | signals                          | direction
//  in      | in_valid_i/in_ready_o, op..now   | into block
//  out     | out_valid_o/out_ready_i, known.. | out of block
//  cfg     | cfg_we_i, cfg_data_i             | into block
//
// One item at a time. Each table read passes the single memory port in a read
// and an act state, and each write adds a write state. A check adds a shift-add
// multiply and a divide by 1000 (reciprocal multiply). Lookup visits entries
// with read and act, eviction with read, act and divide, a clock wrap with read,
// act and write; the worst case is an add on a full table.
// Reset clears count and clock, sets the register to 3600; the table needs no clearing.
// A result waiting in the output register holds off the next item.
`default_nettype none
module per_tag_interval_gate (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [39:0] tag_id_i,
  input  wire logic [7:0]  interval_units_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             known_o,
  output logic             allowed_o,
  output logic [5:0]       slot_o,
  output logic             replaced_o
);
  import ptig_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRead  = 4'd1;
  localparam logic [3:0] StAct   = 4'd2;
  localparam logic [3:0] StDiv   = 4'd3;
  localparam logic [3:0] StDone  = 4'd4;
  localparam logic [3:0] StWrite = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;

  // scan phases
  localparam logic [1:0] PhWrap  = 2'd0;
  localparam logic [1:0] PhFind  = 2'd1;
  localparam logic [1:0] PhEvict = 2'd2;
  localparam logic [1:0] PhCheck = 2'd3;

  logic [3:0]      st_q;
  logic [1:0]      ph_q;
  logic [1:0]      op_q;
  logic [TagW-1:0] tag_q;
  logic [7:0]      units_q;
  logic [31:0]     now_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     last_time_q;
  logic [11:0]     spu_q;
  logic [CntW-1:0] idx_q;
  logic [IdxW-1:0] best_idx_q;
  logic [31:0]     best_q;
  logic            div_sel_q;   // 0: since, 1: elapsed
  logic [31:0]     secs_q;      // sum of quotients
  logic [31:0]     need_q;
  logic [3:0]      mbit_q;
  entry_t          ent_q;
  logic            we;
  logic [IdxW-1:0] addr;
  entry_t          wdata;
  entry_t          rdata;
  logic            res_valid_q;
  logic            known_q, allowed_q, replaced_q;
  logic [5:0]      slot_q;
  logic            done_fire;

  ptig_ram #(.Width(EntryW), .Depth(Entries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign in_ready_o  = (st_q == StIdle) && !(res_valid_q && !out_ready_i);
  assign out_valid_o = res_valid_q;
  assign known_o     = known_q;
  assign allowed_o   = allowed_q;
  assign slot_o      = slot_q;
  assign replaced_o  = replaced_q;
  assign done_fire   = (st_q == StDone) && (!res_valid_q || out_ready_i);

  // shared divide by 1000: reciprocal multiply, one quotient a cycle
  logic [31:0] dividend;
  logic [60:0] div_prod;
  logic [31:0] div_q;
  logic [31:0] secs_sum;
  assign dividend = div_sel_q ? ent_q.elapsed : (last_time_q - ent_q.last_taken);
  assign div_prod = 61'(dividend) * 61'(DivMagic);
  assign div_q    = {9'd0, div_prod[60:38]};
  assign secs_sum = secs_q + div_q;

  // wrap accumulation of one entry
  logic [31:0] wrap_sum;
  assign wrap_sum = rdata.elapsed + (now_q - rdata.last_taken);

  // memory port control
  always_comb begin
    we    = 1'b0;
    addr  = idx_q[IdxW-1:0];
    wdata = ent_q;
    if (st_q == StWrite) begin
      we = 1'b1;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (done_fire) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      cnt_q       <= '0;
      last_time_q <= '0;
      spu_q       <= 12'd3600;
      ph_q        <= PhWrap;
      op_q        <= OpClock;
      tag_q       <= '0;
      units_q     <= '0;
      now_q       <= '0;
      idx_q       <= '0;
      best_idx_q  <= '0;
      best_q      <= '0;
      div_sel_q   <= 1'b0;
      secs_q      <= '0;
      need_q      <= '0;
      mbit_q      <= '0;
      ent_q       <= '0;
      known_q     <= 1'b0;
      allowed_q   <= 1'b0;
      replaced_q  <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        spu_q <= cfg_data_i;
      end
      case (st_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            op_q       <= op_i;
            tag_q      <= tag_id_i & TagMask;
            units_q    <= interval_units_i;
            now_q      <= now_ms_i;
            idx_q      <= '0;
            best_q     <= '0;
            best_idx_q <= '0;
            known_q    <= 1'b0;
            allowed_q  <= 1'b0;
            replaced_q <= 1'b0;
            slot_q     <= '0;
            case (op_i)
              OpClock: begin
                if (now_ms_i < last_time_q && cnt_q != '0) begin
                  ph_q <= PhWrap;
                  st_q <= StRead;
                end else begin
                  last_time_q <= now_ms_i;
                  st_q <= StDone;
                end
              end
              OpCheck, OpAdd: begin
                ph_q <= PhFind;
                st_q <= (cnt_q != '0) ? StRead : StAct;
              end
              default: begin
                cnt_q <= '0;
                st_q  <= StDone;
              end
            endcase
          end
        end
        StRead: begin
          st_q <= StAct;  // read data lands next cycle
        end
        StAct: begin
          case (ph_q)
            PhWrap: begin
              ent_q <= '{tag: rdata.tag, interval: rdata.interval,
                         elapsed: (wrap_sum < rdata.elapsed) ? 32'hFFFF_FFFF : wrap_sum,
                         last_taken: now_q};
              st_q  <= StWrite;
            end
            PhFind: begin
              if (idx_q < cnt_q && rdata.tag == tag_q) begin
                slot_q <= 6'(idx_q);
                known_q <= 1'b1;
                if (op_q == OpCheck) begin
                  ent_q <= rdata;
                  ph_q <= PhCheck;
                  div_sel_q <= 1'b0;
                  secs_q <= '0; need_q <= '0; mbit_q <= '0;
                  st_q <= StMul;
                end else begin
                  ent_q <= '{tag: rdata.tag, interval: units_q,
                             elapsed: 32'hFFFF_FFFF, last_taken: last_time_q};
                  st_q <= StWrite;
                end
              end else if (idx_q + 1'b1 < cnt_q) begin
                idx_q <= idx_q + 1'b1;
                st_q  <= StRead;
              end else if (op_q == OpCheck) begin
                st_q <= StDone;
              end else if (cnt_q < CntW'(Entries)) begin
                idx_q   <= cnt_q;
                slot_q  <= 6'(cnt_q);
                known_q <= 1'b1;
                cnt_q   <= cnt_q + 1'b1;
                ent_q   <= '{tag: tag_q, interval: units_q,
                             elapsed: 32'hFFFF_FFFF, last_taken: last_time_q};
                st_q    <= StWrite;
              end else begin
                ph_q  <= PhEvict;
                idx_q <= '0;
                st_q  <= StRead;
              end
            end
            default: begin  // PhEvict / PhCheck: capture and divide
              ent_q <= rdata;
              div_sel_q <= 1'b0;
              secs_q <= '0;
              st_q <= StDiv;
            end
          endcase
        end
        StMul: begin
          // shift-add interval * seconds_per_unit, one bit a cycle
          if (ent_q.interval[mbit_q[2:0]]) begin
            need_q <= need_q + (32'(spu_q) << mbit_q[2:0]);
          end
          if (mbit_q == 4'd7) begin
            st_q <= StDiv;
          end
          mbit_q <= mbit_q + 1'b1;
        end
        StDiv: begin
          if (!div_sel_q) begin
            secs_q    <= div_q;
            div_sel_q <= 1'b1;
          end else if (ph_q == PhCheck) begin
            if (secs_sum >= need_q) begin
              allowed_q <= 1'b1;
              ent_q     <= '{tag: ent_q.tag, interval: ent_q.interval,
                             elapsed: 32'd0, last_taken: last_time_q};
              idx_q     <= CntW'(slot_q);
              st_q      <= StWrite;
            end else begin
              st_q <= StDone;
            end
          end else begin
            if (secs_sum > best_q) begin
              best_q     <= secs_sum;
              best_idx_q <= idx_q[IdxW-1:0];
            end
            if (idx_q + 1'b1 < cnt_q) begin
              idx_q <= idx_q + 1'b1;
              st_q  <= StRead;
            end else begin
              idx_q      <= CntW'((secs_sum > best_q) ? idx_q[IdxW-1:0] : best_idx_q);
              slot_q     <= 6'((secs_sum > best_q) ? idx_q[IdxW-1:0] : best_idx_q);
              known_q    <= 1'b1;
              replaced_q <= 1'b1;
              ent_q      <= '{tag: tag_q, interval: units_q,
                              elapsed: 32'hFFFF_FFFF, last_taken: last_time_q};
              st_q       <= StWrite;
            end
          end
        end
        StWrite: begin
          if (ph_q == PhWrap && idx_q + 1'b1 < cnt_q) begin
            idx_q <= idx_q + 1'b1;
            st_q  <= StRead;
          end else begin
            if (ph_q == PhWrap) begin
              last_time_q <= now_q;
            end
            st_q <= StDone;
          end
        end
        StDone: begin
          if (done_fire) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: dv/ptig_checker.sv
// Checker for the per-tag interval gate: predicts each result and compares it
`timescale 1ns / 100ps
module ptig_checker
  import ptig_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [39:0] tag_id_i,
  input  wire logic [7:0]  interval_units_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        known_i,
  input  wire logic        allowed_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic        replaced_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               evictions_o,
  output int               allows_o
);

  typedef struct packed {
    logic       known;
    logic       allowed;
    logic [5:0] slot;
    logic       replaced;
  } gate_result_t;

  // Shadow table and registers
  logic [TagW-1:0] sh_tag      [Entries];
  logic [7:0]      sh_interval [Entries];
  logic [31:0]     sh_elapsed  [Entries];
  logic [31:0]     sh_taken    [Entries];
  int unsigned     sh_count;
  logic [31:0]     sh_time;
  logic [11:0]     sh_spu;

  gate_result_t gate_q[$];

  function automatic logic [31:0] idle_secs(int unsigned i);
    logic [31:0] d;
    d = sh_time - sh_taken[i];
    return d / MsPerSec + sh_elapsed[i] / MsPerSec;
  endfunction

  function automatic int find_tag(logic [TagW-1:0] t);
    for (int unsigned i = 0; i < sh_count; i++)
      if (sh_tag[i] == t) return int'(i);
    return -1;
  endfunction

  // Apply one item to the shadow table and return what the block should answer
  function automatic gate_result_t predict_gate(logic [1:0] op, logic [TagW-1:0] tag_in,
                                                logic [7:0] units, logic [31:0] now);
    gate_result_t r;
    logic [TagW-1:0] tag;
    logic [32:0] sum;
    logic [31:0] need, best, e;
    int s;
    r = '0;
    tag = tag_in & TagMask;
    case (op)
      OpClock: begin
        if (now < sh_time) begin
          for (int unsigned i = 0; i < sh_count; i++) begin
            sum = {1'b0, sh_elapsed[i]} + {1'b0, now - sh_taken[i]};
            sh_elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            sh_taken[i] = now;
          end
        end
        sh_time = now;
      end
      OpCheck: begin
        s = find_tag(tag);
        if (s >= 0) begin
          need = sh_interval[s] * sh_spu;
          r.known = 1'b1;
          r.slot = s[5:0];
          if (idle_secs(s) >= need) begin
            r.allowed = 1'b1;
            sh_elapsed[s] = '0;
            sh_taken[s] = sh_time;
          end
        end
      end
      OpAdd: begin
        s = find_tag(tag);
        if (s < 0) begin
          if (sh_count < Entries) begin
            s = int'(sh_count);
            sh_count++;
          end else begin
            best = '0;
            s = 0;
            for (int unsigned i = 0; i < sh_count; i++) begin
              e = idle_secs(i);
              if (e > best) begin
                best = e;
                s = int'(i);
              end
            end
            r.replaced = 1'b1;
          end
          sh_tag[s] = tag;
        end
        sh_interval[s] = units;
        sh_taken[s] = sh_time;
        sh_elapsed[s] = 32'hFFFF_FFFF;
        r.known = 1'b1;
        r.slot = s[5:0];
      end
      default: sh_count = 0;
    endcase
    return r;
  endfunction

  // Watch the channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    gate_result_t exp_r;
    if (!rst_ni) begin
      sh_count = 0;
      sh_time = '0;
      sh_spu = 12'd3600;
      gate_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      evictions_o <= 0;
      allows_o <= 0;
    end else begin
      if (cfg_we_i) sh_spu = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (gate_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = gate_q.pop_front();
          if (exp_r != {known_i, allowed_i, slot_i, replaced_i}) begin
            if (exp_r.known != known_i)
              $error("known: expected %0d, got %0d", exp_r.known, known_i);
            if (exp_r.allowed != allowed_i)
              $error("allowed: expected %0d, got %0d", exp_r.allowed, allowed_i);
            if (exp_r.slot != slot_i)
              $error("slot: expected %0d, got %0d", exp_r.slot, slot_i);
            if (exp_r.replaced != replaced_i)
              $error("replaced: expected %0d, got %0d", exp_r.replaced, replaced_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (exp_r.replaced) evictions_o <= evictions_o + 1;
          if (exp_r.allowed) allows_o <= allows_o + 1;
        end
      end
      if (in_valid_i && in_ready_i)
        gate_q.push_back(predict_gate(op_i, tag_id_i, interval_units_i, now_ms_i));
      pending_o <= gate_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
// Testbench top: stimulus, handshake pacing and verdict for the interval gate
`timescale 1ns / 100ps
module tb;
  import ptig_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OpClock;
  logic [39:0] tag_id = '0;
  logic [7:0]  units = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        known, allowed, replaced;
  logic [5:0]  slot;

  int fail_count, pending, evictions, allows;
  int tx_idle_pct, rx_idle_pct;
  bit rx_hold_req = 1'b0;
  logic [39:0] tag_pool [96];
  logic [31:0] cur_time = '0;
  int n_items = 0;

  always #1 clk_i = ~clk_i;

  per_tag_interval_gate dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .tag_id_i(tag_id), .interval_units_i(units), .now_ms_i(now_ms),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .known_o(known), .allowed_o(allowed), .slot_o(slot), .replaced_o(replaced)
  );

  ptig_checker chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .op_i(op), .tag_id_i(tag_id), .interval_units_i(units), .now_ms_i(now_ms),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .known_i(known), .allowed_i(allowed), .slot_i(slot), .replaced_i(replaced),
    .fail_count_o(fail_count), .pending_o(pending),
    .evictions_o(evictions), .allows_o(allows)
  );

  // Receiver pacing, with a long hold-off on request
  always @(posedge clk_i) begin
    int hold_left;
    if (rx_hold_req && hold_left == 0) hold_left = 3000;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
      if (hold_left == 0) rx_hold_req = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one item and wait for it to be taken; maybe idle afterwards
  task automatic send_item(logic [1:0] o, logic [39:0] t, logic [7:0] u, logic [31:0] n);
    int gap;
    in_valid <= 1'b1;
    op <= o;
    tag_id <= t;
    units <= u;
    now_ms <= n;
    do @(posedge clk_i); while (!in_ready);
    n_items++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_spu(logic [11:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly known tags and forward time, with wraps, clears and noise mixed in
  task automatic random_item();
    int pick;
    logic [39:0] t;
    logic [31:0] n;
    pick = $urandom_range(99);
    t = ($urandom_range(9) == 0) ? 40'({$urandom, $urandom}) : tag_pool[$urandom_range(95)];
    n = cur_time;
    if (pick < 25) begin
      case ($urandom_range(19))
        0: n = $urandom_range(0, 100000);
        1: n = $urandom;
        default: n = cur_time + $urandom_range(0, 500000);
      endcase
      cur_time = n;
      send_item(OpClock, 40'({$urandom, $urandom}), 8'($urandom), n);
    end else if (pick < 62) begin
      send_item(OpCheck, t, 8'($urandom), $urandom);
    end else if (pick < 98) begin
      send_item(OpAdd, t, 8'($urandom_range(0, 255) >> $urandom_range(0, 7)), $urandom);
    end else begin
      send_item(OpClear, t, 8'($urandom), $urandom);
    end
  endtask

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    foreach (tag_pool[i]) tag_pool[i] = 40'({$urandom, $urandom});
    tx_idle_pct = 28;
    rx_idle_pct = 69;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unknown tag, field extremes, wrap, re-add and clear
    send_item(OpCheck, 40'hFF_FFFF_FFFF, 8'd0, 32'd0);
    send_item(OpAdd, 40'hFF_FFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    send_item(OpAdd, 40'h0, 8'd0, 32'd0);
    send_item(OpCheck, 40'hFF_FFFF_FFFF, 8'd0, 32'd0);
    send_item(OpCheck, 40'hFF_FFFF_FFFF, 8'd0, 32'd0);
    send_item(OpCheck, 40'h0, 8'd255, 32'hFFFF_FFFF);
    send_item(OpClock, 40'h0, 8'd0, 32'hFFFF_FFFF);
    send_item(OpClock, 40'hFF_FFFF_FFFF, 8'd255, 32'd5);
    send_item(OpCheck, 40'h0, 8'd0, 32'd0);
    send_item(OpAdd, 40'h0, 8'd1, 32'd0);
    send_item(OpCheck, 40'h0, 8'd0, 32'd0);
    send_item(OpClock, 40'h0, 8'd0, 32'd0);
    send_item(OpClock, 40'h0, 8'd0, 32'hFFFF_FFFF);
    send_item(OpCheck, 40'hFF_FFFF_FFFF, 8'd0, 32'd0);
    send_item(OpClear, 40'h5A_A5A5_5AA5, 8'd255, 32'hFFFF_FFFF);
    send_item(OpCheck, 40'h0, 8'd0, 32'd0);
    cur_time = 32'hFFFF_FFFF;

    // Zero seconds per unit: every check on a known tag passes
    write_spu(12'd0);
    send_item(OpAdd, 40'hA5_5A5A_A55A, 8'd255, 32'd0);
    send_item(OpCheck, 40'hA5_5A5A_A55A, 8'd0, 32'd0);
    send_item(OpCheck, 40'hA5_5A5A_A55A, 8'd0, 32'd0);
    repeat (200) random_item();

    // Test-mode unit, sender idles less than receiver; long receiver hold-off
    write_spu(12'd1);
    rx_hold_req = 1'b1;
    repeat (550) random_item();

    // Largest unit, idling swapped; one sender pause until all results are in
    write_spu(12'd4095);
    tx_idle_pct = 69;
    rx_idle_pct = 28;
    repeat (250) random_item();
    drain();
    repeat (300) random_item();

    // Small random unit, no idling at all
    write_spu(12'($urandom_range(2, 20)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (350) random_item();

    drain();
    repeat (200) @(posedge clk_i);
    $display("%0d items sent over units 3600, 0, 1, 4095 and a random one", n_items);
    $display("%0d checks allowed, %0d adds evicted an entry", allows, evictions);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
